// ===== hdl/sir_pkg.sv =====
// shared types and constants for the sinc interpolating resampler
// used by sir_ctrl, sir_datapath and the top level; no dependencies
`timescale 1ns / 1ps

package sir_pkg;

    localparam int RATE_W  = 20;
    localparam int PHASE_W = 21;
    localparam int COEF_W  = 18;
    localparam int MAX_OUT = 64;
    localparam int CNT_W   = 7;

    localparam logic [RATE_W-1:0]  RATE_RESET = 20'd65536;
    localparam logic [PHASE_W-1:0] ONE_Q16    = 21'd65536;
    localparam logic [63:0]        PI_Q30     = 64'd3373259426;
    localparam logic [63:0]        SINE_ONE   = 64'd1073741824;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_sample;
        logic start_out;
        logic mac_issue;
        logic load_out;
        logic force_last;
        logic end_item;
    } cmd_t;

    typedef struct packed {
        logic phase_lt_one;
        logic tap_last;
        logic pipe_empty;
    } sts_t;

endpackage

// ===== hdl/sinc_interpolating_resampler.sv =====
// top level of the sinc interpolating resampler: stream ports, config port
// depends on sir_pkg, sir_ctrl and sir_datapath
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: in_sample
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: out_sample, tlast: last_of_run
// cfg       in         cfg_wr_en                      cfg_wr_data: step_rate
//
// one input item is served by the single shared mac unit, which for each output produced
// walks all taps of that output one per cycle and then waits for its pipeline to drain
// reset clears the history through per-entry valid bits, so no clearing pass is needed
// a low m_axis_tready holds the output; the next input is taken once all outputs are out
`timescale 1ns / 1ps

module sinc_interpolating_resampler #(
    parameter int SAMPLE_BITS    = 16,
    parameter int HISTORY_DEPTH  = 64,
    parameter int TAPS_EACH_SIDE = 16,
    parameter int PHASE_STEPS    = 256
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    s_axis_tdata,  // in_sample
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    m_axis_tdata,  // out_sample
    output logic                                        m_axis_tlast,
    input  logic                                        cfg_wr_en,
    input  logic [sir_pkg::RATE_W-1:0]                  cfg_wr_data
);
    import sir_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cmd_t                          cmd;
    sts_t                          sts;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    assign in_sample    = s_axis_tdata[SAMPLE_BITS-1:0];
    assign m_axis_tdata = TDATA_W'($unsigned(out_sample));

    sir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sir_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .TAPS_EACH_SIDE (TAPS_EACH_SIDE),
        .PHASE_STEPS    (PHASE_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (in_sample),
        .out_sample  (out_sample),
        .out_last    (m_axis_tlast)
    );

endmodule

// ===== hdl/sir_ctrl.sv =====
// controller for the resampler: sequences sample write, tap loop, output and phase update
// depends on sir_pkg
`timescale 1ns / 1ps

module sir_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  sir_pkg::sts_t sts,
    output sir_pkg::cmd_t cmd
);
    import sir_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              more_out;

    assign more_out = sts.phase_lt_one && (count_reg < CNT_W'(MAX_OUT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (more_out)
                    state_next = ST_START;
                else
                    state_next = ST_FINISH;
            end
            ST_START:
                state_next = ST_MAC;
            ST_MAC:
            begin
                if (sts.tap_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_OUT;
                count_next = count_reg + CNT_W'(1);
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                count_next = '0;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.wr_sample = in_valid;
            end
            ST_START:
                cmd.start_out = 1'b1;
            ST_MAC:
                cmd.mac_issue = 1'b1;
            ST_ROUND:
            begin
                cmd.load_out   = 1'b1;
                cmd.force_last = (count_reg == CNT_W'(MAX_OUT - 1));
            end
            ST_OUT:
                out_valid = 1'b1;
            ST_FINISH:
                cmd.end_item = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== hdl/sir_datapath.sv =====
// datapath: history ring, phase accumulator, sinc coefficient rom and shared mac
// depends on sir_pkg; driven by sir_ctrl commands
`timescale 1ns / 1ps

module sir_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int HISTORY_DEPTH  = 64,
    parameter int TAPS_EACH_SIDE = 16,
    parameter int PHASE_STEPS    = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sir_pkg::cmd_t                 cmd,
    output sir_pkg::sts_t                 sts,
    input  logic                          cfg_wr_en,
    input  logic [sir_pkg::RATE_W-1:0]    cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_last
);
    import sir_pkg::*;

    localparam int NTAP      = 2 * TAPS_EACH_SIDE + 1;
    localparam int TAP_W     = $clog2(NTAP);
    localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
    localparam int PS_W      = $clog2(PHASE_STEPS);
    localparam int PSV_W     = $clog2(PHASE_STEPS + 1);
    localparam int ROM_DEPTH = (TAPS_EACH_SIDE + 1) * PHASE_STEPS;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int BASE_W    = ROM_AW + 1;
    localparam int PROD_W    = SAMPLE_BITS + COEF_W;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int RND_W     = ACC_W + 1;
    localparam int SH_W      = RND_W - 16;

    // coefficient rom, contents fixed at elaboration, indexed by phase distance
    logic signed [COEF_W-1:0] coef_rom [ROM_DEPTH];

    for (genvar i = 0; i < ROM_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] A  = 64'(i);
        localparam logic [63:0] Q  = A % (2 * PHASE_STEPS);
        localparam logic [63:0] R0 = Q % PHASE_STEPS;
        localparam logic [63:0] R  = (R0 > PHASE_STEPS / 2) ? (PHASE_STEPS - R0) : R0;
        localparam logic [63:0] X  = (PI_Q30 * R) / PHASE_STEPS;
        localparam logic [63:0] T1 = ((((X * X) >> 30) * X) >> 30) / 6;
        localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
        localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
        localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
        localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
        localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
        localparam logic signed [63:0] SR = $signed(X) - $signed(T1) + $signed(T2)
                                          - $signed(T3) + $signed(T4) - $signed(T5)
                                          + $signed(T6);
        localparam logic [63:0] S   = (SR < 0) ? 64'd0
                                    : ((SR > $signed(SINE_ONE)) ? SINE_ONE : $unsigned(SR));
        localparam logic [63:0] NUM = S * 64'(PHASE_STEPS) * 64'd65536;
        localparam logic [63:0] DEN = (A == 64'd0) ? 64'd1 : PI_Q30 * A;
        localparam logic [63:0] MAG = (NUM + DEN / 2) / DEN;
        localparam logic [COEF_W-1:0] VAL = (A == 64'd0) ? COEF_W'(ONE_Q16)
                                          : ((Q >= PHASE_STEPS) ? COEF_W'(64'd0 - MAG)
                                                                : COEF_W'(MAG));
        assign coef_rom[i] = VAL;
    end

    // history ring with per-entry valid bits; an unwritten entry reads as zero
    logic signed [SAMPLE_BITS-1:0] ring [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]      ring_vld_reg;

    logic [RATE_W-1:0]             rate_reg;
    logic [PHASE_W-1:0]            phase_reg;
    logic [PHASE_W-1:0]            phase_sum;
    logic [SLOT_W-1:0]             wp_reg;
    logic [SLOT_W-1:0]             newest_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W:0]               slot_init;
    logic [TAP_W-1:0]              tap_reg;
    logic [PS_W-1:0]               p_reg;
    logic [16+PSV_W-1:0]           p_prod;
    logic signed [BASE_W-1:0]      base_reg;
    logic signed [BASE_W-1:0]      tap_dist;
    logic [ROM_AW-1:0]             rom_addr;

    logic signed [SAMPLE_BITS-1:0] ring_q;
    logic                          vld_q;
    logic signed [COEF_W-1:0]      coef_q;
    logic                          s1_v_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SAMPLE_BITS-1:0] sample_eff;
    logic                          s2_v_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic signed [RND_W-1:0]       rnd;
    logic signed [SH_W-1:0]        sh;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic                          fits;

    assign phase_sum = phase_reg + PHASE_W'(rate_reg);
    assign p_prod    = phase_reg[15:0] * PSV_W'(PHASE_STEPS);

    always_comb
    begin
        slot_init = {1'b0, newest_reg} + (SLOT_W + 1)'(HISTORY_DEPTH - 2 * TAPS_EACH_SIDE);
        if (slot_init >= (SLOT_W + 1)'(HISTORY_DEPTH))
            slot_init = slot_init - (SLOT_W + 1)'(HISTORY_DEPTH);
    end

    always_comb
    begin
        tap_dist = base_reg - $signed({{(BASE_W - PS_W){1'b0}}, p_reg});
        if (tap_dist < 0)
            tap_dist = -tap_dist;
        rom_addr = tap_dist[ROM_AW-1:0];
    end

    assign sts.phase_lt_one = (phase_reg < ONE_Q16);
    assign sts.tap_last     = (tap_reg == TAP_W'(NTAP - 1));
    assign sts.pipe_empty   = !s1_v_reg && !s2_v_reg;

    // ring storage and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_sample)
            ring[wp_reg] <= in_sample;
        ring_q <= ring[slot_reg];
        coef_q <= coef_rom[rom_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            rate_reg     <= RATE_RESET;
            phase_reg    <= '0;
            wp_reg       <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.mac_issue;
            s2_v_reg <= s1_v_reg;
            if (cfg_wr_en)
                rate_reg <= cfg_wr_data;
            if (cmd.wr_sample)
            begin
                ring_vld_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + SLOT_W'(1);
            end
            if (cmd.load_out)
                phase_reg <= phase_sum;
            else if (cmd.end_item)
                phase_reg <= (phase_reg >= ONE_Q16) ? phase_reg - ONE_Q16 : '0;
        end
    end

    // tap sequencing and mac pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.wr_sample)
            newest_reg <= wp_reg;
        vld_q <= ring_vld_reg[slot_reg];
        if (cmd.start_out)
        begin
            p_reg    <= p_prod[16 +: PS_W];
            base_reg <= BASE_W'(-(TAPS_EACH_SIDE * PHASE_STEPS));
            slot_reg <= slot_init[SLOT_W-1:0];
            tap_reg  <= '0;
        end
        else if (cmd.mac_issue)
        begin
            base_reg <= base_reg + BASE_W'(PHASE_STEPS);
            slot_reg <= (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
            tap_reg  <= tap_reg + TAP_W'(1);
        end
        prod_reg <= sample_eff * coef_q;
        if (cmd.start_out)
            acc_reg <= '0;
        else if (s2_v_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign sample_eff = vld_q ? ring_q : '0;

    // round half up then saturate to the sample range
    always_comb
    begin
        rnd  = RND_W'(acc_reg) + RND_W'(32768);
        sh   = SH_W'(rnd >>> 16);
        fits = (sh[SH_W-1:SAMPLE_BITS-1] == '0) || (sh[SH_W-1:SAMPLE_BITS-1] == '1);
        if (fits)
            sat = sh[SAMPLE_BITS-1:0];
        else
            sat = sh[SH_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sample <= sat;
            out_last   <= cmd.force_last || (phase_sum >= ONE_Q16);
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench for sinc_interpolating_resampler: directed and random sample streams,
// step rate changes between phases, outputs checked against an in-bench predictor
// depends on sir_pkg and the resampler rtl only
`timescale 1ns / 1ps

module testbench;

    localparam int                SIDE_TAPS   = 16;
    localparam int                PHASES      = 256;
    localparam int                RING_DEPTH  = 64;
    localparam int                OUT_LIMIT   = 64;
    localparam int                COEF_SPAN   = (SIDE_TAPS + 1) * PHASES;
    localparam longint unsigned   PI_Q30      = 64'd3373259426;
    localparam logic [23:0]       UNIT_PHASE  = 24'd65536;
    localparam int                HOLD_OFF    = 64;
    localparam int                QUIET_LIMIT = 4000;
    localparam int                RANDOM_ITEMS = 140;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [15:0]                 s_axis_tdata = '0;    // in_sample
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [15:0]                 m_axis_tdata;         // out_sample
    logic                        m_axis_tlast;         // last_of_run
    logic                        cfg_wr_en = 1'b0;
    logic [sir_pkg::RATE_W-1:0]  cfg_wr_data = '0;

    // predictor state
    logic signed [15:0]          hist_ring [RING_DEPTH];
    logic [5:0]                  wr_slot;
    logic [23:0]                 phase_acc;
    logic [19:0]                 step_rate;
    longint                      sinc_tab [COEF_SPAN];
    result_t                     pending_outputs [$];

    bit                          src_idle_on = 1'b1;
    bit                          sink_idle_on = 1'b1;
    int                          sink_wait = 0;
    int                          quiet_cycles = 0;
    int                          mismatches = 0;
    int                          samples_sent = 0;
    int                          outputs_checked = 0;
    int                          rate_writes = 0;

    sinc_interpolating_resampler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // q2.30 sine of pi*r/PHASES by the fixed seven-term series
    function automatic longint unsigned sine_q30(int unsigned r);
        longint unsigned x;
        longint unsigned t;
        longint          s;
        int unsigned     k;
        if (r > PHASES / 2)
            r = PHASES - r;
        x = (PI_Q30 * longint'(r)) / PHASES;
        t = x;
        s = longint'(x);
        for (k = 1; k <= 6; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        if (s > (longint'(1) << 30))
            s = longint'(1) << 30;
        return longint'(s);
    endfunction

    function automatic longint sinc_weight(int unsigned tap_dist);
        longint unsigned q;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        if (tap_dist == 0)
            return 65536;
        q = tap_dist % (2 * PHASES);
        num = sine_q30(32'(q % PHASES)) * PHASES * 65536;
        den = PI_Q30 * tap_dist;
        mag = (num + den / 2) / den;
        return (q >= PHASES) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [15:0] interpolate_at(logic [5:0] newest, logic [15:0] frac);
        longint acc;
        longint v;
        int     p;
        int     j;
        int     tap_dist;
        int     slot;
        acc = 0;
        p = int'(frac >> 8);
        for (int k = 0; k <= 2 * SIDE_TAPS; k++)
        begin
            j = k - SIDE_TAPS;
            slot = (newest + RING_DEPTH - 2 * SIDE_TAPS + k) % RING_DEPTH;
            tap_dist = j * PHASES - p;
            if (tap_dist < 0)
                tap_dist = -tap_dist;
            acc += longint'(hist_ring[slot]) * sinc_tab[tap_dist];
        end
        v = (acc + 32768) >>> 16;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_sample(logic [15:0] smp);
        logic [5:0] newest;
        int         count;
        result_t    r;
        newest = wr_slot;
        hist_ring[newest] = smp;
        wr_slot = newest + 6'd1;
        count = 0;
        while (phase_acc < UNIT_PHASE && count < OUT_LIMIT)
        begin
            r.sample = interpolate_at(newest, phase_acc[15:0]);
            r.last = 1'b0;
            pending_outputs.push_back(r);
            phase_acc = phase_acc + {4'b0, step_rate};
            count++;
        end
        if (count > 0)
            pending_outputs[pending_outputs.size() - 1].last = 1'b1;
        // outputs dropped past the cap leave the phase at zero
        phase_acc = (phase_acc >= UNIT_PHASE) ? phase_acc - UNIT_PHASE : 24'd0;
    endtask

    task automatic send_sample(logic [15:0] smp);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_sample(smp);
        samples_sent++;
    endtask

    // hold the sender until every predicted output has been seen
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_rate(logic [19:0] value);
        wait_drained();
        // a request with no output may still be in flight
        repeat (HOLD_OFF) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_rate = value;
        rate_writes++;
    endtask

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 16'($urandom());
        else if (pick < 8)
            return 16'($urandom_range(0, 511) - 256);
        else
            return (pick == 8) ? 16'h7fff : 16'h8000;
    endfunction

    task automatic test_reset_rate();
        logic [15:0] vals [7];
        vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic test_saturation();
        write_rate(20'h08000);
        for (int i = 0; i < 8; i++)
            send_sample(i % 2 ? 16'h8000 : 16'h7fff);
    endtask

    task automatic test_output_cap();
        write_rate(20'h00000);
        send_sample(16'h4000);
        send_sample(16'hc000);
        write_rate(20'd1000);
        send_sample(16'h1234);
        write_rate(20'd1024);
        send_sample(16'hedcb);
    endtask

    task automatic test_no_output();
        write_rate(20'd655360);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());
        write_rate(20'hfffff);
        for (int i = 0; i < 3; i++)
            send_sample(random_sample());
    endtask

    task automatic test_random_stream();
        int          sent;
        int          seg_len;
        int          pick;
        logic [19:0] rate;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rate = 20'($urandom_range(1024, 8191));
            else if (pick == 1)
                rate = 20'($urandom_range(393216, 655360));
            else if (pick == 2)
                rate = 20'($urandom_range(0, 20'hfffff));
            else
                rate = 20'($urandom_range(32768, 131072));
            write_rate(rate);
            src_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            seg_len = (rate < 20'd8192) ? $urandom_range(1, 4) : $urandom_range(8, 20);
            for (int i = 0; i < seg_len; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                send_sample(random_sample());
            end
            sent += seg_len;
        end
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // output side stall, drawn per accepted result
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sink_wait = sink_idle_on ? $urandom_range(0, 8) : 0;
        else if (sink_wait > 0)
            sink_wait--;
        m_axis_tready <= rst_n && (sink_wait == 0);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t unexpected output: expected none, actual sample %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata !== want.sample)
                begin
                    $display("%0t out_sample mismatch: expected %h, actual %h",
                             $time, want.sample, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t last_of_run mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                    mismatches++;
                end
                outputs_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        for (int d = 0; d < COEF_SPAN; d++)
            sinc_tab[d] = sinc_weight(d);
        foreach (hist_ring[i])
            hist_ring[i] = '0;
        wr_slot = '0;
        phase_acc = '0;
        step_rate = 20'd65536;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_rate();
        test_saturation();
        test_output_cap();
        test_no_output();
        test_random_stream();

        wait_drained();
        repeat (HOLD_OFF) @(posedge clk);

        $display("sent %0d samples, checked %0d outputs over %0d step rate writes",
                 samples_sent, outputs_checked, rate_writes);
        $display("rates covered zero, the 64-output cap, 1.0, 10.0 and full scale");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
